// File: rtl/region_arena_bump_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef REGION_ARENA_BUMP_ALLOCATOR_ASSERT_SVH
`define REGION_ARENA_BUMP_ALLOCATOR_ASSERT_SVH

// Condition that must hold at every sampled edge outside reset.
`define RABA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define RABA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RABA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/raba_pkg.sv
// Package with shared widths, codes and types of the region arena allocator.
`default_nettype none

package raba_pkg;

  // Field and register widths
  localparam int CMD_W      = 2;
  localparam int AMOUNT_W   = 17;
  localparam int STATUS_W   = 3;
  localparam int ADDRESS_W  = 16;
  localparam int POSITION_W = 17;
  localparam int SHIFT_W    = 4;
  localparam int SIZE_W     = 13;
  localparam int FILL_W     = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  // Aligned sums: 17-bit amount plus up to 2^15 - 1 of rounding
  localparam int ALIGN_W    = 18;
  localparam int ADDR_CALC_W = 32;
  localparam int SIZE_MAX   = (2 ** SIZE_W) - 1;

  // Parameter defaults
  localparam int REGION_BYTES_DEF = 4096;
  localparam int MAX_REGIONS_DEF  = 16;

  // Register reset values
  localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_RST  = SHIFT_W'(3);
  localparam logic [SIZE_W-1:0]  REGION_BYTES_RST = SIZE_W'(4096);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SHIFT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REWIND = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_NO_REGION  = 3'd3,
    ST_REWIND_IGN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_LOAD,
    S_HOLD
  } state_t;

endpackage

`default_nettype wire

// File: rtl/raba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module raba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/region_arena_bump_allocator.sv
// Top level of the region arena bump allocator: command sequencer over a region fill RAM.
// Alloc, unknown command, zero-count free, ignored rewind: result decided in S_EXEC and registered.
// Free or rewind: S_EXEC, then S_WALK, then S_LOAD for each region walked back (at most MAX_REGIONS - 1),
// which waits on the registered read of the region fill RAM on each step back.
// One transaction at a time; a finished result waits in S_HOLD while the output stalls.
// Reset (rst, synchronous): no regions, position 0, align_shift 3, usable size 4096.
`default_nettype none
`include "region_arena_bump_allocator_assert.svh"

module region_arena_bump_allocator
  import raba_pkg::*;
#(
  parameter int REGION_BYTES = REGION_BYTES_DEF,
  parameter int MAX_REGIONS  = MAX_REGIONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // command channel
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic [CMD_W-1:0]      cmd,
  input  wire logic [AMOUNT_W-1:0]   amount,
  // result channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [ADDRESS_W-1:0]       address,
  output logic [POSITION_W-1:0]      position
);

  // Region index, region count, and the widest position the regions can hold.
  localparam int IDX_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int MADE_W   = $clog2(MAX_REGIONS + 1);
  localparam int FILL_MAX = (REGION_BYTES < SIZE_MAX) ? REGION_BYTES : SIZE_MAX;
  localparam int POS_W    = $clog2(MAX_REGIONS * FILL_MAX + 1);
  localparam int TW       = (POS_W > AMOUNT_W) ? POS_W : AMOUNT_W;
  localparam logic [SIZE_W-1:0] RSIZE_CAP = SIZE_W'(FILL_MAX);

  state_t state, state_next;

  // Configuration registers
  logic [SHIFT_W-1:0] align_shift;
  logic [SIZE_W-1:0]  region_bytes;

  // Accepted command
  logic [CMD_W-1:0]    cmd_q;
  logic [AMOUNT_W-1:0] amount_q;

  // Allocator state. The fill of the current region is kept in cur_offset as well
  // as in the RAM, so only a walk back across regions has to read the RAM.
  logic [IDX_W-1:0]  cur_region, cur_region_next;
  logic [MADE_W-1:0] regions_made, regions_made_next;
  logic [FILL_W-1:0] cur_offset, cur_offset_next;
  logic [POS_W-1:0]  total_pos, total_pos_next;
  logic [POS_W-1:0]  rem, rem_next;

  // Result parked while the output register is still occupied
  status_t              res_status, res_status_next;
  logic [ADDRESS_W-1:0] res_address, res_address_next;

  // Result load
  logic                 rsp_free;
  logic                 rsp_load;
  status_t              load_status;
  logic [ADDRESS_W-1:0] load_address;
  logic                 finish;
  status_t              fin_status;
  logic [ADDRESS_W-1:0] fin_address;

  // Region fill RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [FILL_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [FILL_W-1:0] rd_data;

  // Allocation datapath
  logic [SIZE_W-1:0]      rsize;
  logic [ALIGN_W-1:0]     amask;
  logic [ALIGN_W-1:0]     al;
  logic [ALIGN_W-1:0]     al_end;
  logic [ALIGN_W-1:0]     size_up;
  logic                   fits;
  logic                   too_large;
  logic                   has_next;
  logic                   can_make;
  logic [IDX_W-1:0]       new_idx;
  logic [IDX_W-1:0]       idx_sel;
  logic [ALIGN_W-1:0]     al_sel;
  logic [ADDR_CALC_W-1:0] addr_full;

  // Free datapath
  logic [TW-1:0]     total_ext;
  logic [TW-1:0]     amount_ext;
  logic              over_pos;
  logic [POS_W-1:0]  free_rem;
  logic [POS_W-1:0]  rewind_rem;
  logic [FILL_W-1:0] off_eff;
  logic [POS_W-1:0]  off_ext;
  logic [FILL_W-1:0] off_left;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Every region below regions_made had its fill written when it was made, so the
  // walk never reads an entry that was not written: the RAM needs no clearing.
  raba_ram #(
    .WIDTH (FILL_W),
    .DEPTH (MAX_REGIONS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Fetch the fill of the region below the current one; only used on a step back.
  assign ram_raddr = cur_region - IDX_W'(1);

  // Usable size, clamped to the region stride.
  assign rsize = (region_bytes > RSIZE_CAP) ? RSIZE_CAP : region_bytes;

  // Align the current offset, then test the request against the usable size.
  assign amask     = (ALIGN_W'(1) << align_shift) - ALIGN_W'(1);
  assign al        = (ALIGN_W'(cur_offset) + amask) & ~amask;
  assign al_end    = al + ALIGN_W'(amount_q);
  assign fits      = (regions_made != '0) && (al_end <= ALIGN_W'(rsize));
  assign size_up   = (ALIGN_W'(amount_q) + amask) & ~amask;
  assign too_large = size_up > ALIGN_W'(rsize);

  // Region advance: reuse an already made region, else make one while allowed.
  assign has_next = (regions_made != '0) &&
                    ((MADE_W'(cur_region) + MADE_W'(1)) < regions_made);
  assign can_make = regions_made < MADE_W'(MAX_REGIONS);
  assign new_idx  = (regions_made == '0) ? '0 : cur_region + IDX_W'(1);

  assign idx_sel   = fits ? cur_region : new_idx;
  assign al_sel    = fits ? al : '0;
  assign addr_full = ADDR_CALC_W'(idx_sel) * ADDR_CALC_W'(REGION_BYTES) +
                     ADDR_CALC_W'(al_sel);

  // Free count clamped to the position; rewind converts a target into a count.
  assign total_ext  = TW'(total_pos);
  assign amount_ext = TW'(amount_q);
  assign over_pos   = amount_ext > total_ext;
  assign free_rem   = over_pos ? total_pos : POS_W'(amount_ext);
  assign rewind_rem = POS_W'(total_ext - amount_ext);

  // Offset seen by one walk step: the register first, the RAM after a step back.
  assign off_eff  = (state == S_LOAD) ? rd_data : cur_offset;
  assign off_ext  = POS_W'(off_eff);
  assign off_left = off_eff - FILL_W'(rem);

  always_comb begin
    state_next        = state;
    cur_region_next   = cur_region;
    regions_made_next = regions_made;
    cur_offset_next   = cur_offset;
    total_pos_next    = total_pos;
    rem_next          = rem;
    res_status_next   = res_status;
    res_address_next  = res_address;
    finish            = 1'b0;
    fin_status        = ST_OK;
    fin_address       = '0;
    rsp_load          = 1'b0;
    load_status       = res_status;
    load_address      = res_address;
    ram_we            = 1'b0;
    ram_waddr         = cur_region;
    ram_wdata         = cur_offset;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_q)
          CMD_ALLOC: begin
            finish = 1'b1;
            if (amount_q == '0) begin
              fin_status = ST_ZERO_SIZE;
            end else if (fits) begin
              // Bump within the current region
              cur_offset_next = FILL_W'(al_end);
              total_pos_next  = total_pos + POS_W'(al_end) - POS_W'(cur_offset);
              ram_we          = 1'b1;
              ram_waddr       = cur_region;
              ram_wdata       = FILL_W'(al_end);
              fin_address     = addr_full[ADDRESS_W-1:0];
            end else if (too_large) begin
              fin_status = ST_TOO_LARGE;
            end else if (has_next || can_make) begin
              // Open the next region at offset zero; its tail was never counted
              cur_region_next = new_idx;
              if (!has_next) begin
                regions_made_next = regions_made + MADE_W'(1);
              end
              cur_offset_next = FILL_W'(amount_q);
              total_pos_next  = total_pos + POS_W'(amount_q);
              ram_we          = 1'b1;
              ram_waddr       = new_idx;
              ram_wdata       = FILL_W'(amount_q);
              fin_address     = addr_full[ADDRESS_W-1:0];
            end else begin
              fin_status = ST_NO_REGION;
            end
          end

          CMD_FREE: begin
            if (free_rem == '0) begin
              finish = 1'b1;
            end else begin
              rem_next   = free_rem;
              state_next = S_WALK;
            end
          end

          CMD_REWIND: begin
            if (over_pos) begin
              finish     = 1'b1;
              fin_status = ST_REWIND_IGN;
            end else if (rewind_rem == '0) begin
              finish = 1'b1;
            end else begin
              rem_next   = rewind_rem;
              state_next = S_WALK;
            end
          end

          default: begin
            finish = 1'b1;
          end
        endcase
      end

      S_WALK, S_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = cur_region;
        if (rem <= off_ext) begin
          // Remainder lies within this region: trim it and stop
          cur_offset_next = off_left;
          total_pos_next  = total_pos - rem;
          ram_wdata       = off_left;
          finish          = 1'b1;
        end else begin
          // Empty this region and step back
          rem_next        = rem - off_ext;
          total_pos_next  = total_pos - off_ext;
          cur_offset_next = '0;
          ram_wdata       = '0;
          if (cur_region == '0) begin
            total_pos_next = '0;
            finish         = 1'b1;
          end else begin
            cur_region_next = cur_region - IDX_W'(1);
            state_next      = S_LOAD;
          end
        end
      end

      S_HOLD: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Deliver straight into the output register if it is free, else park the result.
    if (finish) begin
      if (rsp_free) begin
        rsp_load     = 1'b1;
        load_status  = fin_status;
        load_address = fin_address;
        state_next   = S_IDLE;
      end else begin
        res_status_next  = fin_status;
        res_address_next = fin_address;
        state_next       = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      align_shift  <= ALIGN_SHIFT_RST;
      region_bytes <= REGION_BYTES_RST;
      cur_region   <= '0;
      regions_made <= '0;
      cur_offset   <= '0;
      total_pos    <= '0;
      rem          <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cur_region   <= cur_region_next;
      regions_made <= regions_made_next;
      cur_offset   <= cur_offset_next;
      total_pos    <= total_pos_next;
      rem          <= rem_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_ALIGN_SHIFT:  align_shift  <= cfg_data[SHIFT_W-1:0];
          CFG_REGION_BYTES: region_bytes <= cfg_data[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cmd_q    <= cmd;
      amount_q <= amount;
    end
    res_status  <= res_status_next;
    res_address <= res_address_next;
    if (rsp_load) begin
      status   <= load_status;
      address  <= load_address;
      position <= POSITION_W'(total_pos_next);
    end
  end

  `RABA_ASSERT_ALWAYS(a_cur_below_made, clk, rst,
    regions_made == '0 || MADE_W'(cur_region) < regions_made,
    "current region lies beyond the regions made")
  `RABA_ASSERT_ALWAYS(a_offset_in_pos, clk, rst,
    TW'(cur_offset) <= TW'(total_pos),
    "current offset exceeds the total position")
  `RABA_ASSERT_IMPLY(a_empty_no_pos, clk, rst,
    regions_made == '0, total_pos == '0,
    "position held with no region made")
  `RABA_ASSERT_IMPLY(a_walk_has_rem, clk, rst,
    state == S_WALK || state == S_LOAD, rem != '0,
    "region walk running with nothing left to free")
  `RABA_ASSERT_NEXT(a_made_monotonic, clk, rst,
    state == S_EXEC || state == S_WALK || state == S_LOAD,
    regions_made >= $past(regions_made),
    "region count went down")

endmodule

`default_nettype wire

// File: verif/region_arena_bump_allocator_tb.sv
// Self-checking testbench for the region arena bump allocator.
`timescale 1ns / 1ps

module region_arena_bump_allocator_tb;
  import raba_pkg::*;

  localparam int REGION_BYTES  = REGION_BYTES_DEF;
  localparam int MAX_REGIONS   = MAX_REGIONS_DEF;
  localparam int REG_IDX_W     = $clog2(MAX_REGIONS);
  localparam int PHASES        = 12;
  localparam int PHASE_CMDS    = 160;
  localparam int SETTLE_CYCLES = 32;    // longest walk back is well under this
  localparam int LONG_HOLD     = 300;   // receiver hold-off used for back-pressure
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transaction before giving up

  // cmd value outside the defined set; the block must treat it as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic               pause;  // marker: hold the sender until all results are back
    logic [CMD_W-1:0]    op;
    logic [AMOUNT_W-1:0] amt;
  } arena_cmd_t;

  typedef struct packed {
    status_t               st;
    logic [ADDRESS_W-1:0]  addr;
    logic [POSITION_W-1:0] pos;
  } arena_result_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // DUT inputs, all known from time zero
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  req_valid = 1'b0;
  logic [CMD_W-1:0]      cmd       = '0;
  logic [AMOUNT_W-1:0]   amount    = '0;
  logic                  rsp_stall = 1'b0;

  // DUT outputs
  logic                  req_stall;
  logic                  rsp_valid;
  logic [STATUS_W-1:0]   status;
  logic [ADDRESS_W-1:0]  address;
  logic [POSITION_W-1:0] position;

  region_arena_bump_allocator #(
    .REGION_BYTES(REGION_BYTES),
    .MAX_REGIONS (MAX_REGIONS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .cmd      (cmd),
    .amount   (amount),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status   (status),
    .address  (address),
    .position (position)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the allocator: registers and region bookkeeping at RTL widths.
  // Only touched at accept time (driver) or while the block is idle (config).
  // ---------------------------------------------------------------------------
  logic [SHIFT_W-1:0]    cfg_shift  = ALIGN_SHIFT_RST;
  logic [SIZE_W-1:0]     cfg_usable = REGION_BYTES_RST;
  logic [FILL_W-1:0]     fill_mem [MAX_REGIONS] = '{default: '0};
  logic [REG_IDX_W-1:0]  cur_reg    = '0;
  logic [REG_IDX_W:0]    made_cnt   = '0;
  logic [FILL_W-1:0]     cur_off    = '0;
  logic [POSITION_W-1:0] pos_total  = '0;

  // Traffic bookkeeping
  arena_cmd_t    pending_cmds [$];
  arena_result_t owed_results [$];
  arena_cmd_t    cur_item;
  int            cmds_issued  = 0;
  int            results_seen = 0;
  int            err_count    = 0;
  int            quiet_cycles = 0;

  // Idle shaping, shared between the stimulus and the two channel processes
  int unsigned   tx_wait = 0;
  int unsigned   rx_wait = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;
  bit            tx_rush = 1'b0;
  int            hold_asked = 0;
  int            hold_taken = 0;

  // Coverage tallies for the closing summary
  int            status_tally [5] = '{default: 0};
  int            deepest_made = 0;
  int            settings_used = 1;

  int unsigned   shift_plan  [PHASES] = '{3, 0, 12, 15, 4, 2, 0, 13, 1, 6, 0, 0};
  int unsigned   usable_plan [PHASES] = '{4096, 1, 4096, 4096, 64, 0, 8191, 4096,
                                          300, 1000, 0, 0};

  // Usable bytes per region; anything above the stride folds back to it
  function automatic int unsigned usable_bytes();
    return (32'(cfg_usable) > REGION_BYTES) ? REGION_BYTES : 32'(cfg_usable);
  endfunction

  function automatic int unsigned align_up(input int unsigned v);
    int unsigned a;
    a = 32'd1 << cfg_shift;
    return (v + a - 1) & ~(a - 1);
  endfunction

  // Bump inside the current region, else step to the next one (made or new)
  function automatic void bump_alloc(input int unsigned size, output status_t st,
                                     output int unsigned addr);
    int unsigned lim;
    int unsigned al;
    lim  = usable_bytes();
    st   = ST_OK;
    addr = 0;
    if (size == 0) begin
      st = ST_ZERO_SIZE;
      return;
    end
    if (made_cnt > 0) begin
      al = align_up(32'(cur_off));
      if (al + size <= lim) begin
        pos_total         = POSITION_W'(32'(pos_total) + al + size -
                                        32'(fill_mem[cur_reg]));
        cur_off           = FILL_W'(al + size);
        fill_mem[cur_reg] = cur_off;
        addr              = 32'(cur_reg) * REGION_BYTES + al;
        return;
      end
    end
    if (align_up(size) > lim) begin
      st = ST_TOO_LARGE;
      return;
    end
    if (made_cnt > 0 && 32'(cur_reg) + 1 < 32'(made_cnt)) begin
      cur_reg = cur_reg + REG_IDX_W'(1);
    end else if (32'(made_cnt) < MAX_REGIONS) begin
      if (made_cnt > 0) cur_reg = cur_reg + REG_IDX_W'(1);
      else cur_reg = '0;
      made_cnt = made_cnt + (REG_IDX_W + 1)'(1);
    end else begin
      st = ST_NO_REGION;
      return;
    end
    cur_off           = FILL_W'(size);
    fill_mem[cur_reg] = FILL_W'(size);
    pos_total         = POSITION_W'(32'(pos_total) + size);
    addr              = 32'(cur_reg) * REGION_BYTES;
  endfunction

  // Roll back by a byte count, clamped to the position, across regions
  function automatic void roll_back(input int unsigned size);
    int unsigned left;
    int          g;
    left = (size > 32'(pos_total)) ? 32'(pos_total) : size;
    for (g = 0; left > 0 && g <= MAX_REGIONS; g++) begin
      if (made_cnt == 0) break;
      if (left <= 32'(cur_off)) begin
        cur_off           = FILL_W'(32'(cur_off) - left);
        pos_total         = POSITION_W'(32'(pos_total) - left);
        fill_mem[cur_reg] = cur_off;
        break;
      end
      pos_total         = pos_total - POSITION_W'(cur_off);
      left              = left - 32'(cur_off);
      fill_mem[cur_reg] = '0;
      if (cur_reg == 0) begin
        cur_off   = '0;
        pos_total = '0;
        break;
      end
      cur_reg = cur_reg - REG_IDX_W'(1);
      cur_off = fill_mem[cur_reg];
    end
  endfunction

  // Outcome of one command; advances the shadow state
  function automatic arena_result_t arena_outcome(input arena_cmd_t it);
    arena_result_t r;
    status_t       st;
    int unsigned   addr;
    st   = ST_OK;
    addr = 0;
    case (it.op)
      CMD_ALLOC:  bump_alloc(32'(it.amt), st, addr);
      CMD_FREE:   roll_back(32'(it.amt));
      CMD_REWIND: begin
        if (32'(it.amt) > 32'(pos_total)) st = ST_REWIND_IGN;
        else roll_back(32'(pos_total) - 32'(it.amt));
      end
      default: ;
    endcase
    r.st   = st;
    r.addr = addr[ADDRESS_W-1:0];
    r.pos  = pos_total;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued commands, predict each one as it is accepted.
  // A pause marker at the head holds the sender until every result is back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic          offer;
    arena_result_t outcome;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      offer = req_valid;
      if (req_valid && !req_stall) begin
        outcome = arena_outcome(cur_item);
        owed_results.push_back(outcome);
        status_tally[outcome.st]++;
        if (int'(made_cnt) > deepest_made) deepest_made = int'(made_cnt);
        cmds_issued++;
        offer = 1'b0;
        if ($urandom_range(31, 0) == 0) tx_calm = !tx_calm;
        tx_wait = (tx_rush || tx_calm) ? 0 : $urandom_range(7, 0);
      end
      if (!offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_cmds.size() > 0) begin
          if (pending_cmds[0].pause) begin
            if (cmds_issued == results_seen) void'(pending_cmds.pop_front());
          end else begin
            cur_item = pending_cmds.pop_front();
            cmd    <= cur_item.op;
            amount <= cur_item.amt;
            offer  = 1'b1;
          end
        end
      end
      // one update of valid per edge: it never drops and rises in the same step
      req_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction, and
  // drive the stall, including the long hold-off asked for by the stimulus.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    arena_result_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding (status %0d)", status));
        end else begin
          want = owed_results.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                      results_seen, status, want.st));
          if (address !== want.addr)
            report_mismatch($sformatf("result %0d address %0h, wanted %0h",
                                      results_seen, address, want.addr));
          if (position !== want.pos)
            report_mismatch($sformatf("result %0d position %0d, wanted %0d",
                                      results_seen, position, want.pos));
          results_seen++;
        end
        if ($urandom_range(31, 0) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(7, 0);
      end
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        rx_wait    = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up after a long stretch with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results owed",
               QUIET_LIMIT, owed_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Keep the queue short so random choices see a recent position
  task automatic feed(input logic pause, input logic [CMD_W-1:0] op,
                      input int unsigned amt);
    arena_cmd_t it;
    it.pause = pause;
    it.op    = op;
    it.amt   = amt[AMOUNT_W-1:0];
    while (pending_cmds.size() >= 4) @(posedge clk);
    pending_cmds.push_back(it);
  endtask

  // Wait until the block has nothing in flight, then let it settle
  task automatic drain();
    while (pending_cmds.size() != 0 || req_valid || cmds_issued != results_seen)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; junk in the unused shift bits is ignored
  task automatic program_regs(input int unsigned shift, input int unsigned usable);
    logic [CFG_DATA_W-1:0] shift_word;
    shift_word = CFG_DATA_W'(($urandom_range(511, 0) << SHIFT_W) | (shift & 4'hF));
    cfg_write <= 1'b1;
    cfg_index <= CFG_ALIGN_SHIFT;
    cfg_data  <= shift_word;
    @(posedge clk);
    cfg_index <= CFG_REGION_BYTES;
    cfg_data  <= CFG_DATA_W'(usable);
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_shift  = shift_word[SHIFT_W-1:0];
    cfg_usable = CFG_DATA_W'(usable);
    settings_used++;
  endtask

  // Mostly allocations sized to the region, frees that sometimes cross
  // regions or overshoot, and rewinds aimed around the current position
  task automatic feed_random();
    int unsigned lim;
    int unsigned pick;
    int unsigned span;
    lim  = usable_bytes();
    if (lim == 0) lim = 1;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      pick = $urandom_range(99, 0);
      if (pick < 3) feed(1'b0, CMD_ALLOC, 0);
      else if (pick < 10) feed(1'b0, CMD_ALLOC, $urandom_range(65536, lim));
      else if (pick < 20) feed(1'b0, CMD_ALLOC, $urandom_range(lim, (lim > 8) ? lim - 8 : 1));
      else begin
        span = lim >> $urandom_range(4, 1);
        if (span == 0) span = 1;
        feed(1'b0, CMD_ALLOC, $urandom_range(span, 1));
      end
    end else if (pick < 80) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) feed(1'b0, CMD_FREE, 0);
      else if (pick < 12) feed(1'b0, CMD_FREE, $urandom_range(65536, 32'(pos_total)));
      else if (pick < 25) feed(1'b0, CMD_FREE, $urandom_range(4 * lim, lim + 1));
      else feed(1'b0, CMD_FREE, $urandom_range(lim, 1));
    end else if (pick < 98) begin
      span = 32'(pos_total) + 32'(pos_total) / 8 + 16;
      if (span > 65536) span = 65536;
      feed(1'b0, CMD_REWIND, $urandom_range(span, 0));
    end else begin
      feed(1'b0, CMD_UNUSED, $urandom_range(65536, 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on the reset settings (8-byte alignment, full regions)
    feed(1'b0, CMD_FREE, 0);            // free with no region made yet
    feed(1'b0, CMD_ALLOC, 0);           // zero-size allocation
    feed(1'b0, CMD_REWIND, 5);          // rewind above an empty position
    feed(1'b0, CMD_ALLOC, 65536);       // far too large for a region
    feed(1'b0, CMD_UNUSED, 7);          // undefined command is a no-op
    for (i = 0; i < MAX_REGIONS; i++)   // fill every region to the brim
      feed(1'b0, CMD_ALLOC, REGION_BYTES);
    feed(1'b0, CMD_ALLOC, 1);           // region limit reached
    feed(1'b0, CMD_FREE, 5000);         // walk back across two regions
    feed(1'b0, CMD_REWIND, 65536);      // target above the position
    feed(1'b0, CMD_FREE, 65536);        // overshoot: clamp to an empty arena
    drain();

    // Random phases, each under its own register setting; the state carries
    // over so a shrinking region size meets regions already filled past it
    for (p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) program_regs($urandom_range(15, 0), $urandom_range(8191, 1));
      else program_regs(shift_plan[p], usable_plan[p]);
      for (i = 0; i < PHASE_CMDS; i++) begin
        // back-pressure: stall the result side for a long stretch while
        // commands arrive back to back, so the block has to stall its input
        if (p == 0 && i == 80) begin
          tx_rush = 1'b1;
          hold_asked++;
        end
        if (p == 0 && i == 120) tx_rush = 1'b0;
        // hold the sender now and then until every result is back
        if (i % 50 == 49) feed(1'b1, CMD_ALLOC, 0);
        feed_random();
      end
      drain();
    end

    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

    $display("ran %0d commands under %0d register settings, up to %0d regions in use",
             cmds_issued, settings_used, deepest_made);
    $display("outcomes: ok %0d, zero size %0d, too large %0d, no region %0d, ignored %0d",
             status_tally[ST_OK], status_tally[ST_ZERO_SIZE], status_tally[ST_TOO_LARGE],
             status_tally[ST_NO_REGION], status_tally[ST_REWIND_IGN]);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
